>>> src/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and the month length table for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  // default widths for the year register and the day count
  localparam int unsigned YearBitsDef  = 16;
  localparam int unsigned CountBitsDef = 16;

  // days in one four-year leap cycle
  localparam int unsigned DaysPerBlock = 1461;
  // remainder / day accumulator width, holds 31 + 1460
  localparam int unsigned AccW         = 11;

  // command codes on the action field
  typedef enum logic [2:0] {
    ACT_LOAD = 3'd0,
    ACT_NEXT = 3'd1,
    ACT_PREV = 3'd2,
    ACT_ADD  = 3'd3,
    ACT_SUB  = 3'd4
  } action_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;     // beat accepted on the input channel
    logic div_step;  // take one leap cycle off the count, year moves by four
    logic prep;      // seed the walk with the remaining days
    logic walk_step; // one month of the walk
    logic out_load;  // copy the date into the output register
  } cds_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;  // count is below one leap cycle
    logic walk_done; // current walk step settles the day
  } cds_status_t;

  // month length, february gets the leap day when leap is set
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

>>> src/calendar_date_stepper_top.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_top
// Day/month/year date register: load with check, step a day either way, or
// add or subtract a day count. One result beat per command beat.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | action_i load_day_i load_month_i
//          |                         | load_year_i day_count_i
//  out     | out_valid_o/out_ready_i | cur_day_o cur_month_o cur_year_o bad_date_o
//
//  load and unused actions pass straight to the output register; a single day
//  step first takes one or two month-walk steps.
//  add and subtract: divide steps take whole leap cycles of 1461 days off the
//  count (year moves by four each), one step seeds the walk with the remaining
//  days, then walk steps move one month each until the day settles, and the
//  result goes to the output register.
//  one command at a time; a new beat is taken while the last result waits.
//  rst_ni clears the date to day 1, month 1, year 0, with no beat pending.
module calendar_date_stepper_top #(
  parameter int unsigned YEAR_BITS  = cds_pkg::YearBitsDef,
  parameter int unsigned COUNT_BITS = cds_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            action_i,
  input  logic [4:0]            load_day_i,
  input  logic [3:0]            load_month_i,
  input  logic [YEAR_BITS-1:0]  load_year_i,
  input  logic [COUNT_BITS-1:0] day_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [4:0]            cur_day_o,
  output logic [3:0]            cur_month_o,
  output logic [YEAR_BITS-1:0]  cur_year_o,
  output logic                  bad_date_o
);
  import cds_pkg::*;

  cds_cmd_t    cmd;
  cds_status_t status;

  // sequencer
  cds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // date registers and arithmetic
  cds_datapath #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (action_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .day_count_i  (day_count_i),
    .cur_day_o    (cur_day_o),
    .cur_month_o  (cur_month_o),
    .cur_year_o   (cur_year_o),
    .bad_date_o   (bad_date_o)
  );

endmodule

>>> src/cds_ctrl.sv
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer for the date stepper: accepts a beat, runs the divide and the
// month walk in the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            action_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cds_pkg::cds_status_t  status_i,
  output cds_pkg::cds_cmd_t     cmd_o
);
  import cds_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.start    = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_NEXT, ACT_PREV: state_d = ST_WALK;
            ACT_ADD, ACT_SUB:   state_d = ST_DIV;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output beat pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/cds_datapath.sv
// ----------------------------------------------------------------------------
// cds_datapath
// Date registers, leap-cycle reduction by repeated subtraction, one-month-a-step
// walk forward or back, load check and the output register.
// ----------------------------------------------------------------------------
module cds_datapath #(
  parameter int unsigned YEAR_BITS  = cds_pkg::YearBitsDef,
  parameter int unsigned COUNT_BITS = cds_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cds_pkg::cds_cmd_t     cmd_i,
  output cds_pkg::cds_status_t  status_o,
  input  logic [2:0]            action_i,
  input  logic [4:0]            load_day_i,
  input  logic [3:0]            load_month_i,
  input  logic [YEAR_BITS-1:0]  load_year_i,
  input  logic [COUNT_BITS-1:0] day_count_i,
  output logic [4:0]            cur_day_o,
  output logic [3:0]            cur_month_o,
  output logic [YEAR_BITS-1:0]  cur_year_o,
  output logic                  bad_date_o
);
  import cds_pkg::*;

  localparam int unsigned NumW = (COUNT_BITS > AccW) ? COUNT_BITS : AccW;
  localparam logic [NumW-1:0]      BlockDays     = NumW'(DaysPerBlock);
  localparam logic [YEAR_BITS-1:0] YearsPerBlock = YEAR_BITS'(4);

  // date state
  logic [4:0]            day_q, day_d;
  logic [3:0]            month_q, month_d;
  logic [YEAR_BITS-1:0]  year_q, year_d;
  logic                  bad_q, bad_d;
  // working registers
  logic                  add_q, add_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [NumW-1:0]       num_q, num_d;
  // output register
  logic [4:0]            out_day_q;
  logic [3:0]            out_month_q;
  logic [YEAR_BITS-1:0]  out_year_q;
  logic                  out_bad_q;

  logic                  num_ge;
  logic [AccW-1:0]       num_rem;
  logic [4:0]            dim_cur;
  logic                  add_fits;
  logic                  sub_fits;
  logic [3:0]            prev_month;
  logic [YEAR_BITS-1:0]  prev_year;
  logic [3:0]            next_month;
  logic [YEAR_BITS-1:0]  next_year;
  logic                  load_ok;
  logic [AccW-1:0]       day_ext;

  // leap-cycle reduction: one whole cycle comes off the count per step
  assign num_ge  = (num_q >= BlockDays);
  assign num_rem = num_q[AccW-1:0];

  // month walk helpers
  assign day_ext    = AccW'(day_q);
  assign dim_cur    = days_in(month_q, year_q[1:0] == 2'b00);
  assign add_fits   = (acc_q <= AccW'(dim_cur));
  assign sub_fits   = (acc_q < day_ext);
  assign next_month = (month_q == 4'd12) ? 4'd1 : month_q + 4'd1;
  assign next_year  = (month_q == 4'd12) ? year_q + 1'b1 : year_q;
  assign prev_month = (month_q <= 4'd1) ? 4'd12 : month_q - 4'd1;
  assign prev_year  = (month_q <= 4'd1) ? year_q - 1'b1 : year_q;

  // load check
  assign load_ok = (load_month_i >= 4'd1) && (load_month_i <= 4'd12) &&
                   (load_day_i != 5'd0) &&
                   (load_day_i <= days_in(load_month_i, load_year_i[1:0] == 2'b00));

  assign status_o.div_last  = ~num_ge;
  assign status_o.walk_done = add_q ? add_fits : sub_fits;

  // next values
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    bad_d   = bad_q;
    add_d   = add_q;
    acc_d   = acc_q;
    num_d   = num_q;

    if (cmd_i.start) begin
      bad_d = 1'b0;
      num_d = NumW'(day_count_i);
      case (action_e'(action_i))
        ACT_LOAD: begin
          if (load_ok) begin
            day_d   = load_day_i;
            month_d = load_month_i;
            year_d  = load_year_i;
          end else begin
            bad_d = 1'b1;
          end
        end
        ACT_NEXT: begin
          add_d = 1'b1;
          acc_d = day_ext + AccW'(1);
        end
        ACT_PREV: begin
          add_d = 1'b0;
          acc_d = AccW'(1);
        end
        ACT_ADD: begin
          add_d = 1'b1;
          acc_d = '0;
        end
        ACT_SUB: begin
          add_d = 1'b0;
          acc_d = '0;
        end
        default: ;
      endcase
    end

    // each whole leap cycle moves the year by four
    if (cmd_i.div_step && num_ge) begin
      num_d  = num_q - BlockDays;
      year_d = add_q ? year_q + YearsPerBlock : year_q - YearsPerBlock;
    end

    // the remaining days seed the walk
    if (cmd_i.prep) begin
      if (add_q) begin
        acc_d = num_rem + day_ext;
      end else begin
        acc_d = num_rem;
      end
    end

    if (cmd_i.walk_step) begin
      if (add_q) begin
        if (add_fits) begin
          day_d = acc_q[4:0];
        end else begin
          acc_d   = acc_q - AccW'(dim_cur);
          month_d = next_month;
          year_d  = next_year;
        end
      end else begin
        if (sub_fits) begin
          day_d = day_q - acc_q[4:0];
        end else begin
          acc_d   = acc_q - day_ext;
          month_d = prev_month;
          year_d  = prev_year;
          day_d   = days_in(prev_month, prev_year[1:0] == 2'b00);
        end
      end
    end
  end

  // date registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= 5'd1;
      month_q <= 4'd1;
      year_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      bad_q   <= bad_d;
    end
  end

  // working registers and output register
  always_ff @(posedge clk_i) begin
    add_q <= add_d;
    acc_q <= acc_d;
    num_q <= num_d;
    if (cmd_i.out_load) begin
      out_day_q   <= day_q;
      out_month_q <= month_q;
      out_year_q  <= year_q;
      out_bad_q   <= bad_q;
    end
  end

  assign cur_day_o   = out_day_q;
  assign cur_month_o = out_month_q;
  assign cur_year_o  = out_year_q;
  assign bad_date_o  = out_bad_q;

endmodule

>>> tb/sv/tb_calendar_date_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_stepper_top
// Drives load, day step and day count commands into the date stepper with
// bursty input and a stalling output, predicts each returned date in a small
// scoreboard and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_calendar_date_stepper_top;
  import cds_pkg::*;

  localparam int unsigned YearW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned LeapCycleDays = 1461;

  // action codes that leave the date as it is
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int unsigned RandomCmds = 250;

  typedef struct {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [YearW-1:0] year;
    logic             bad;
  } date_beat_t;

  // date model and queue of dates still owed by the block
  class date_scoreboard;
    int               cur_day;
    int               cur_month;
    logic [YearW-1:0] cur_year;
    date_beat_t       owed_dates[$];
    int               errors;

    function void clear_date();
      cur_day   = 1;
      cur_month = 1;
      cur_year  = '0;
      owed_dates.delete();
      errors    = 0;
    endfunction

    function int month_days(int month, logic [YearW-1:0] year);
      int n;
      case (month)
        2:       n = (year[1:0] == 2'b00) ? 29 : 28;
        4, 6, 9, 11: n = 30;
        default: n = 31;
      endcase
      return n;
    endfunction

    // whole leap cycles first, then month by month
    function void advance_days(int n);
      int acc;
      cur_year = cur_year + YearW'(4 * (n / LeapCycleDays));
      acc = cur_day + (n % LeapCycleDays);
      while (acc > month_days(cur_month, cur_year)) begin
        acc = acc - month_days(cur_month, cur_year);
        cur_month++;
        if (cur_month > 12) begin
          cur_month = 1;
          cur_year  = cur_year + 1'b1;
        end
      end
      cur_day = acc;
    endfunction

    // borrow whole previous months while the day would reach zero
    function void rewind_days(int n);
      int rem;
      cur_year = cur_year - YearW'(4 * (n / LeapCycleDays));
      rem = n % LeapCycleDays;
      while (rem >= cur_day) begin
        rem = rem - cur_day;
        if (cur_month <= 1) begin
          cur_month = 12;
          cur_year  = cur_year - 1'b1;
        end else begin
          cur_month--;
        end
        cur_day = month_days(cur_month, cur_year);
      end
      cur_day = cur_day - rem;
    endfunction

    function void note_command(logic [2:0] act, logic [4:0] ld, logic [3:0] lm,
                               logic [YearW-1:0] ly, logic [CountW-1:0] cnt);
      date_beat_t res;
      res.bad = 1'b0;
      case (act)
        ACT_LOAD: begin
          if (lm >= 1 && lm <= 12 && ld >= 1 && ld <= month_days(lm, ly)) begin
            cur_day   = ld;
            cur_month = lm;
            cur_year  = ly;
          end else begin
            res.bad = 1'b1;
          end
        end
        ACT_NEXT: advance_days(1);
        ACT_PREV: rewind_days(1);
        ACT_ADD:  advance_days(int'(cnt));
        ACT_SUB:  rewind_days(int'(cnt));
        default: ;
      endcase
      res.day   = 5'(cur_day);
      res.month = 4'(cur_month);
      res.year  = cur_year;
      owed_dates.push_back(res);
    endfunction

    function void check_result(logic [4:0] d, logic [3:0] m, logic [YearW-1:0] y,
                               logic bad);
      date_beat_t want;
      if (owed_dates.size() == 0) begin
        $display("%0t: result beat with none owed: %0d/%0d/%0d bad %0b",
                 $time, d, m, y, bad);
        errors++;
        return;
      end
      want = owed_dates.pop_front();
      if (d !== want.day) begin
        $display("%0t: cur_day expected %0d actual %0d", $time, want.day, d);
        errors++;
      end
      if (m !== want.month) begin
        $display("%0t: cur_month expected %0d actual %0d", $time, want.month, m);
        errors++;
      end
      if (y !== want.year) begin
        $display("%0t: cur_year expected %0d actual %0d", $time, want.year, y);
        errors++;
      end
      if (bad !== want.bad) begin
        $display("%0t: bad_date expected %0b actual %0b", $time, want.bad, bad);
        errors++;
      end
    endfunction

    function int pending();
      return owed_dates.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        action_i;
  logic [4:0]        load_day_i;
  logic [3:0]        load_month_i;
  logic [YearW-1:0]  load_year_i;
  logic [CountW-1:0] day_count_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [4:0]        cur_day_o;
  logic [3:0]        cur_month_o;
  logic [YearW-1:0]  cur_year_o;
  logic              bad_date_o;

  date_scoreboard sb;
  int             burst_left;

  calendar_date_stepper_top #(
    .YEAR_BITS  (YearW),
    .COUNT_BITS (CountW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .day_count_i  (day_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cur_day_o    (cur_day_o),
    .cur_month_o  (cur_month_o),
    .cur_year_o   (cur_year_o),
    .bad_date_o   (bad_date_o)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // receiver stall pattern, reloaded whenever the 6-bit age counter wraps
  logic [15:0] stall_pat;
  logic [5:0]  stall_age;
  always @(posedge clk_i) begin
    if (stall_age == '0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hFFFF;
        1:       stall_pat <= 16'($urandom);
        2:       stall_pat <= 16'($urandom) & 16'($urandom);
        default: stall_pat <= 16'($urandom) | 16'($urandom);
      endcase
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    stall_age   <= stall_age + 1'b1;
    out_ready_i <= stall_pat[0];
  end

  // result beats are compared as they are taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(cur_day_o, cur_month_o, cur_year_o, bad_date_o);
  end

  // present one command, hold it until taken, then maybe leave a gap
  task automatic send_cmd(logic [2:0] act, logic [4:0] ld, logic [3:0] lm,
                          logic [YearW-1:0] ly, logic [CountW-1:0] cnt);
    int gap;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    load_day_i   <= ld;
    load_month_i <= lm;
    load_year_i  <= ly;
    day_count_i  <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(act, ld, lm, ly, cnt);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_load(logic [4:0] ld, logic [3:0] lm, logic [YearW-1:0] ly);
    send_cmd(ACT_LOAD, ld, lm, ly, CountW'($urandom));
  endtask

  task automatic send_count(logic [2:0] act, logic [CountW-1:0] cnt);
    send_cmd(act, 5'($urandom), 4'($urandom), YearW'($urandom), cnt);
  endtask

  // random part: mostly valid dates and stepping, some bad loads and spare codes
  task automatic run_random();
    int               pick;
    logic [3:0]       m;
    logic [YearW-1:0] y;
    logic [CountW-1:0] cnt;
    for (int i = 0; i < RandomCmds; i++) begin
      pick = $urandom_range(0, 99);
      cnt  = ($urandom_range(0, 9) < 3) ? CountW'($urandom) : CountW'($urandom_range(0, 400));
      if (pick < 12) begin
        m = 4'($urandom_range(1, 12));
        y = ($urandom_range(0, 3) == 0) ? YearW'($urandom_range(0, 3)) - 2'd2
                                        : YearW'($urandom);
        send_load(5'($urandom_range(1, sb.month_days(m, y))), m, y);
      end else if (pick < 17) begin
        send_load(5'($urandom), 4'($urandom), YearW'($urandom));
      end else if (pick < 40) begin
        send_count(ACT_NEXT, CountW'($urandom));
      end else if (pick < 62) begin
        send_count(ACT_PREV, CountW'($urandom));
      end else if (pick < 78) begin
        send_count(ACT_ADD, cnt);
      end else if (pick < 94) begin
        send_count(ACT_SUB, cnt);
      end else begin
        send_count(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), CountW'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_date();
    burst_left   = 1;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_LOAD;
    load_day_i   = '0;
    load_month_i = '0;
    load_year_i  = '0;
    day_count_i  = '0;
    out_ready_i  = 1'b0;
    stall_pat    = 16'hFFFF;
    stall_age    = 6'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stepping around the reset date and through the year wrap
    send_count(ACT_NEXT, '0);
    send_count(ACT_PREV, '1);
    send_count(ACT_PREV, '0);
    send_count(ACT_NEXT, '1);
    // leap day accepted, refused off a leap year, and rejected fields
    send_load(5'd29, 4'd2, 16'd2024);
    send_load(5'd29, 4'd2, 16'd2023);
    send_load(5'd0, 4'd5, 16'd100);
    send_load(5'd31, 4'd4, 16'd100);
    send_load(5'd10, 4'd0, 16'd100);
    send_load(5'd10, 4'd13, 16'd100);
    send_load(5'd31, 4'd15, 16'hFFFF);
    // last day of the largest year rolls over to year zero
    send_load(5'd31, 4'd12, 16'hFFFF);
    send_count(ACT_NEXT, '0);
    // through february of a leap year and back out of march
    send_load(5'd28, 4'd2, 16'd2024);
    send_count(ACT_NEXT, '0);
    send_count(ACT_NEXT, '0);
    send_load(5'd1, 4'd3, 16'd0);
    send_count(ACT_PREV, '0);
    // zero, one leap cycle and the largest count both ways, then the first and last spare codes
    send_count(ACT_ADD, '0);
    send_count(ACT_SUB, '0);
    send_count(ACT_ADD, CountW'(LeapCycleDays));
    send_count(ACT_SUB, CountW'(LeapCycleDays));
    send_count(ACT_ADD, '1);
    send_count(ACT_SUB, '1);
    send_count(ACT_SPARE_FIRST, '1);
    send_count(ACT_SPARE_LAST, '0);

    run_random();
    in_valid_i <= 1'b0;

    // drain owed dates, then watch for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0)
      $display("tb_calendar_date_stepper_top: clean");
    else
      $display("tb_calendar_date_stepper_top: errors");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_calendar_date_stepper_top: errors");
    $finish;
  end

endmodule
